// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the debouncer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define MKED_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("debouncer assertion failed");

// Check that a condition never holds outside reset
`define MKED_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("debouncer forbidden condition seen");

`else

`define MKED_ASSERT(lbl, clk, rst, prop)
`define MKED_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== rtl/core/mked_pkg.sv =====
// Shared constants, types and functions of the multi-key debouncer
package mked_pkg;

   localparam int CHANNELS   = 5;
   localparam int COUNT_BITS = 10;
   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LATCH_CH   = 3;
   localparam int WAKE_CH    = 4;

   // configuration register map
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 10;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHORT_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LATCH_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_ENABLE = 2'd2;

   localparam logic [COUNT_BITS-1:0] SHORT_TIMEOUT_RST  = COUNT_BITS'(30);
   localparam logic [COUNT_BITS-1:0] LATCH_TIMEOUT_RST  = COUNT_BITS'(300);
   localparam logic [CHANNELS-1:0]   CHANNEL_ENABLE_RST = CHANNELS'(15);

   // event queue between the lanes and the output serialiser
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [COUNT_BITS-1:0] timeout;
      logic                  enable;
      logic                  fall_only;
   } lane_cfg_type;

   typedef struct packed {
      logic fire;
      logic released;
   } lane_evt_type;

   typedef struct packed {
      logic [CHANNELS-1:0] fire;
      logic [CHANNELS-1:0] released;
   } tick_evt_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [CH_BITS-1:0] lowest_index(input logic [CHANNELS-1:0] mask);
      logic [CH_BITS-1:0] idx;
      idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = CH_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/mked_lane.sv =====
// One debounce lane: edge detect, settling countdown and expiry check
`include "assert_macros.svh"

module mked_lane
   import mked_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         pin,
   input  lane_cfg_type cfg,
   output lane_evt_type evt
);

   logic                  armed_ff, armed_in;
   logic                  sampled_ff, sampled_in;
   logic                  prev_ff, prev_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  expire;
   logic                  edge_hit;

   // expiry uses the armed bit from the start of the tick
   assign expire   = accept && !armed_ff && (count_ff <= COUNT_BITS'(1));
   assign edge_hit = accept && armed_ff && cfg.enable && (pin != prev_ff)
                     && !(cfg.fall_only && pin);

   assign evt.fire     = expire && (pin == sampled_ff);
   assign evt.released = pin;

   // advance countdown, re-arm at expiry, restart on a new edge
   always_comb begin
      armed_in   = armed_ff;
      sampled_in = sampled_ff;
      prev_in    = prev_ff;
      count_in   = count_ff;
      if (accept) begin
         prev_in = pin;
         if (!armed_ff) begin
            if (count_ff <= COUNT_BITS'(1)) begin
               count_in = '0;
               armed_in = 1'b1;
            end else begin
               count_in = count_ff - COUNT_BITS'(1);
            end
         end
         if (edge_hit) begin
            armed_in   = 1'b0;
            sampled_in = pin;
            count_in   = cfg.timeout;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b1;
         sampled_ff <= 1'b1;
         prev_ff    <= 1'b1;
         count_ff   <= '0;
      end else begin
         armed_ff   <= armed_in;
         sampled_ff <= sampled_in;
         prev_ff    <= prev_in;
         count_ff   <= count_in;
      end
   end

   `MKED_ASSERT(a_armed_idle, clock, reset, armed_ff |-> (count_ff == '0))
   `MKED_ASSERT(a_fire_disarmed, clock, reset, evt.fire |-> !armed_ff)
   `MKED_ASSERT(a_count_runs, clock, reset,
                (accept && !armed_ff && (count_ff > COUNT_BITS'(1))) |=> !armed_ff)

endmodule

// ===== rtl/core/mked_merge.sv =====
// Event queue and serialiser: one result beat per cycle while rsp_stall is low, lowest channel first
`include "assert_macros.svh"

module mked_merge
   import mked_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_accept,
   input  tick_evt_type       tick_evt,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CH_BITS-1:0] rsp_channel,
   output logic               rsp_released,
   output logic               rsp_last_event
);

   tick_evt_type             fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [CHANNELS-1:0]      cur_mask_ff, cur_mask_in;
   logic [CHANNELS-1:0]      cur_rel_ff, cur_rel_in;
   logic [CHANNELS-1:0]      low_bit;
   logic [CHANNELS-1:0]      rest;
   logic                     push, pop, out_take, need_load;

   // queue only ticks that produced events
   assign req_stall = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign push      = in_accept && (|tick_evt.fire);

   // serialise the current tick's event mask
   assign low_bit   = cur_mask_ff & (~cur_mask_ff + CHANNELS'(1));
   assign rest      = cur_mask_ff & ~low_bit;
   assign rsp_valid = |cur_mask_ff;
   assign out_take  = rsp_valid && !rsp_stall;
   assign need_load = !rsp_valid || (out_take && (rest == '0));
   assign pop       = need_load && (count_ff != '0);

   assign rsp_channel    = lowest_index(cur_mask_ff);
   assign rsp_released   = |(low_bit & cur_rel_ff);
   assign rsp_last_event = (rest == '0);

   always_comb begin
      wr_ptr_in   = push ? wr_ptr_ff + FIFO_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + FIFO_PTR_BITS'(1) : rd_ptr_ff;
      count_in    = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
      cur_mask_in = out_take ? rest : cur_mask_ff;
      cur_rel_in  = cur_rel_ff;
      if (pop) begin
         cur_mask_in = fifo_ff[rd_ptr_ff].fire;
         cur_rel_in  = fifo_ff[rd_ptr_ff].released;
      end
   end

   // hold queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= tick_evt;
      end
   end

   always_ff @(posedge clock) begin
      cur_rel_ff <= cur_rel_in;
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         cur_mask_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         cur_mask_ff <= cur_mask_in;
      end
   end

   `MKED_ASSERT(a_count_bound, clock, reset, count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
   `MKED_NEVER(a_push_full, clock, reset, push && req_stall)
   `MKED_ASSERT(a_tick_continues, clock, reset,
                (out_take && !rsp_last_event) |=> rsp_valid)

endmodule

// ===== rtl/core/multi_key_edge_debouncer_unit.sv =====
// Top level of the multi-key edge debouncer: registers, lanes and merge
// An accepted tick with events is written into the event queue and then loaded into
// the current-mask register, whose nonzero mask raises rsp_valid.
// Throughput: one tick per cycle; each event takes one output beat, and a
// four-entry event queue stalls the input when the result side falls behind.
// Reset (synchronous, active high) arms all keys, sets levels released, clears
// countdowns and loads timeouts 30 and 300 with the wakeup key disabled.
`include "assert_macros.svh"

module multi_key_edge_debouncer_unit
   import mked_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CHANNELS-1:0]      req_pin_levels,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CH_BITS-1:0]       rsp_channel,
   output logic                     rsp_released,
   output logic                     rsp_last_event,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   logic [COUNT_BITS-1:0] short_ff;
   logic [COUNT_BITS-1:0] latch_ff;
   logic [CHANNELS-1:0]   enable_ff;
   logic                  in_accept;
   logic                  csr_write;
   tick_evt_type          tick_evt;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign in_accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= SHORT_TIMEOUT_RST;
         latch_ff  <= LATCH_TIMEOUT_RST;
         enable_ff <= CHANNEL_ENABLE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SHORT_TIMEOUT:  short_ff  <= csr_data[COUNT_BITS-1:0];
            CSR_LATCH_TIMEOUT:  latch_ff  <= csr_data[COUNT_BITS-1:0];
            CSR_CHANNEL_ENABLE: enable_ff <= csr_data[CHANNELS-1:0];
            default: ;
         endcase
      end
   end

   // one lane per key
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      lane_cfg_type cfg;
      lane_evt_type evt;

      assign cfg.timeout   = (c == LATCH_CH) ? latch_ff : short_ff;
      assign cfg.enable    = enable_ff[c];
      assign cfg.fall_only = (c == WAKE_CH);

      mked_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (in_accept),
         .pin    (req_pin_levels[c]),
         .cfg    (cfg),
         .evt    (evt)
      );

      assign tick_evt.fire[c]     = evt.fire;
      assign tick_evt.released[c] = evt.released;
   end

   mked_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .in_accept      (in_accept),
      .tick_evt       (tick_evt),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_channel    (rsp_channel),
      .rsp_released   (rsp_released),
      .rsp_last_event (rsp_last_event)
   );

   `MKED_ASSERT(a_channel_range, clock, reset,
                rsp_valid |-> (rsp_channel < CH_BITS'(CHANNELS)))
   `MKED_ASSERT(a_wake_no_release, clock, reset,
                (rsp_valid && (rsp_channel == CH_BITS'(WAKE_CH))) |-> !rsp_released)
   `MKED_ASSERT(a_csr_hold, clock, reset,
                !$past(csr_write) |-> $stable(enable_ff))

endmodule
